@@ rtl/core/nearest_neighbor_l2_search_top_defines.svh @@
// Assertion macros for the search block checker.
// Expects clk and rst_n in the scope of each use.
`ifndef NEAREST_NEIGHBOR_L2_SEARCH_TOP_DEFINES_SVH
`define NEAREST_NEIGHBOR_L2_SEARCH_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define NNL2_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nnl2 check failed");

// Consequent holds in the cycle after the antecedent.
`define NNL2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnl2 check failed");

`endif

@@ rtl/core/nnl2_pkg.sv @@
// Package for the nearest neighbor L2 search block: sizes, codes, result struct.
// No dependencies; used by the engine, the top level and the checker.
package nnl2_pkg;

    localparam int DIM        = 128;
    localparam int MAX_ROWS   = 1024;
    localparam int VALUE_BITS = 16;

    localparam int DIM_W   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W  = ROW_W + DIM_W;
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int SQ_W    = 2 * VALUE_BITS;

    localparam int IN_ROW_W   = 10;
    localparam int IN_DIM_W   = 7;
    localparam int IN_VAL_W   = 16;
    localparam int INDEX_W    = 11;
    localparam int DIST_W     = 39;
    localparam int CFG_ROWS_W = 11;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [PADDR_W-3:0] REG_REF_ROWS = '0;

    localparam logic [INDEX_W-1:0] INDEX_NONE = '1;
    localparam logic [DIM_W-1:0]   DIM_LAST   = DIM_W'(DIM - 1);

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  dist_sq;
    } nnl2_res_t;

endpackage

@@ rtl/core/nearest_neighbor_l2_search_top.sv @@
// Channel   Handshake            Payload
// input     in_valid/in_ready    cmd, row, dim, value
// output    out_valid/out_ready  best_index, best_dist_sq
// config    APB psel/penable     paddr, pwdata, prdata (ref_rows at 0x0)
//
// Load items and non-final query items leave the engine idle and ready for the next item.
// A final query item starts a scan of min(ref_rows, 1024) rows of 128 values, or none with no rows:
// one reference store read per cycle feeds a single multiply-accumulate.
// rst_n clears control state; memories hold no reset value.
// A result waits in the output register while the next items are taken; a
// second result holds the engine and stalls input until out_ready.
//
// Top level of the nearest neighbor L2 search block: config register and
// output register. Depends on nnl2_pkg and nnl2_engine.
module nearest_neighbor_l2_search_top
    import nnl2_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [IN_ROW_W-1:0]       row,
    input  logic [IN_DIM_W-1:0]       dim,
    input  logic [IN_VAL_W-1:0]       value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [INDEX_W-1:0] best_index,
    output logic [DIST_W-1:0]         best_dist_sq
);

    logic [CFG_ROWS_W-1:0]     ref_rows_reg;
    logic                      out_valid_reg;
    logic signed [INDEX_W-1:0] best_index_reg;
    logic [DIST_W-1:0]         best_dist_sq_reg;
    nnl2_res_t                 res;
    logic                      res_ready;
    logic                      sel_ref_rows;

    assign pready       = 1'b1;
    assign sel_ref_rows = (paddr[PADDR_W-1:2] == REG_REF_ROWS);
    assign prdata       = sel_ref_rows ? DATA_W'(ref_rows_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_rows_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && sel_ref_rows)
        begin
            ref_rows_reg <= pwdata[CFG_ROWS_W-1:0];
        end
    end

    nnl2_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .row       (row),
        .dim       (dim),
        .value     (value),
        .ref_rows  (ref_rows_reg),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            best_index_reg   <= res.index;
            best_dist_sq_reg <= res.dist_sq;
        end
    end

    assign out_valid    = out_valid_reg;
    assign best_index   = best_index_reg;
    assign best_dist_sq = best_dist_sq_reg;

endmodule

@@ rtl/core/nnl2_engine.sv @@
// Search engine: reference store and query buffer memories, scan sequencer,
// squared-difference pipeline and running minimum. Depends on nnl2_pkg.
module nnl2_engine
    import nnl2_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [IN_ROW_W-1:0]   row,
    input  logic [IN_DIM_W-1:0]   dim,
    input  logic [IN_VAL_W-1:0]   value,
    input  logic [CFG_ROWS_W-1:0] ref_rows,
    output nnl2_res_t             res,
    input  logic                  res_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [VALUE_BITS-1:0] ref_mem [MAX_ROWS*DIM];
    logic [VALUE_BITS-1:0] qry_mem [DIM];

    logic [ROW_W-1:0]      row_cnt_reg;
    logic [DIM_W-1:0]      dim_cnt_reg;
    logic [CNT_W-1:0]      rows_reg;
    logic                  found_reg;
    logic [ROW_W-1:0]      best_row_reg;
    logic [DIST_W-1:0]     best_dist_reg;
    logic [DIST_W-1:0]     acc_reg;

    logic [VALUE_BITS-1:0] ref_q_reg;
    logic [VALUE_BITS-1:0] qry_q_reg;
    logic [VALUE_BITS-1:0] diff_reg;
    logic [SQ_W-1:0]       sq_reg;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                  s1_first_reg, s2_first_reg, s3_first_reg;
    logic                  s1_last_reg, s2_last_reg, s3_last_reg;
    logic                  s1_end_reg, s2_end_reg, s3_end_reg;
    logic [ROW_W-1:0]      s1_row_reg, s2_row_reg, s3_row_reg;

    logic                  accept;
    logic                  dim_ok;
    logic                  row_ok;
    logic                  ref_we;
    logic                  qry_we;
    logic                  trigger;
    logic [VALUE_BITS-1:0] val_clip;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CNT_W-1:0]      rows_sat;
    logic                  issue;
    logic                  last_dim;
    logic                  last_row;
    logic [DIST_W-1:0]     sum;
    logic                  better;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign dim_ok   = int'(dim) < DIM;
    assign row_ok   = int'(row) < MAX_ROWS;
    assign val_clip = value[VALUE_BITS-1:0];
    assign wr_addr  = {row[ROW_W-1:0], dim[DIM_W-1:0]};
    assign ref_we   = accept && (cmd == CMD_LOAD) && dim_ok && row_ok;
    assign qry_we   = accept && (cmd == CMD_QUERY) && dim_ok;
    assign trigger  = qry_we && (dim[DIM_W-1:0] == DIM_LAST);
    assign rows_sat = (int'(ref_rows) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : CNT_W'(ref_rows);

    assign issue    = (state_reg == ST_SCAN);
    assign rd_addr  = {row_cnt_reg, dim_cnt_reg};
    assign last_dim = (dim_cnt_reg == DIM_LAST);
    assign last_row = (CNT_W'(row_cnt_reg) + CNT_W'(1)) == rows_reg;

    assign sum    = (s3_first_reg ? '0 : acc_reg) + DIST_W'(sq_reg);
    assign better = !found_reg || (sum < best_dist_reg);

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[wr_addr] <= val_clip;
        end
        if (issue)
        begin
            ref_q_reg <= ref_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qry_we)
        begin
            qry_mem[dim[DIM_W-1:0]] <= val_clip;
        end
        if (issue)
        begin
            qry_q_reg <= qry_mem[dim_cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (dim_cnt_reg == '0);
        s1_last_reg  <= last_dim;
        s1_end_reg   <= last_dim && last_row;
        s1_row_reg   <= row_cnt_reg;

        diff_reg     <= (ref_q_reg > qry_q_reg) ? (ref_q_reg - qry_q_reg)
                                                : (qry_q_reg - ref_q_reg);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_end_reg   <= s1_end_reg;
        s2_row_reg   <= s1_row_reg;

        sq_reg       <= diff_reg * diff_reg;
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_end_reg   <= s2_end_reg;
        s3_row_reg   <= s2_row_reg;

        if (s3_valid_reg)
        begin
            acc_reg <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            dim_cnt_reg   <= '0;
            rows_reg      <= '0;
            found_reg     <= 1'b0;
            best_row_reg  <= '0;
            best_dist_reg <= '0;
        end
        else
        begin
            if (s3_valid_reg && s3_last_reg && better)
            begin
                found_reg     <= 1'b1;
                best_dist_reg <= sum;
                best_row_reg  <= s3_row_reg;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (trigger)
                    begin
                        found_reg   <= 1'b0;
                        rows_reg    <= rows_sat;
                        row_cnt_reg <= '0;
                        dim_cnt_reg <= '0;
                        state_reg   <= (rows_sat == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (last_dim)
                    begin
                        dim_cnt_reg <= '0;
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                        if (last_row)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        dim_cnt_reg <= dim_cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (s3_valid_reg && s3_end_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid   = (state_reg == ST_DONE);
    assign res.index   = found_reg ? INDEX_W'(best_row_reg) : INDEX_NONE;
    assign res.dist_sq = found_reg ? best_dist_reg : '0;

endmodule

@@ rtl/core/nnl2_checker.sv @@
// Port-level checker for the search block, bound to the top level.
// Depends on nnl2_pkg and nearest_neighbor_l2_search_top_defines.svh.
`include "nearest_neighbor_l2_search_top_defines.svh"

module nnl2_checker
    import nnl2_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      cmd,
    input logic [IN_DIM_W-1:0]       dim,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [INDEX_W-1:0] best_index,
    input logic [DIST_W-1:0]         best_dist_sq
);

    logic                        trig_acc;
    logic                        load_acc;
    logic                        out_stall;
    logic [INDEX_W+DIST_W-1:0]   out_payload;

    assign trig_acc = in_valid && in_ready && (cmd == CMD_QUERY) && (int'(dim) == DIM - 1);
    assign load_acc = in_valid && in_ready && (cmd == CMD_LOAD);
    assign out_stall   = out_valid && !out_ready;
    assign out_payload = {best_index, best_dist_sq};

    `NNL2_ASSERT_NEXT(a_trigger_blocks, trig_acc, !in_ready)
    `NNL2_ASSERT_NEXT(a_load_keeps_ready, load_acc, in_ready)
    `NNL2_ASSERT_NOW(a_empty_zero_dist, out_valid && (&best_index), best_dist_sq == '0)
    `NNL2_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))

endmodule

bind nearest_neighbor_l2_search_top nnl2_checker u_nnl2_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for nearest_neighbor_l2_search_top: drives loads and queries,
// predicts each nearest-row match and compares it. Depends on nnl2_pkg and the RTL.
module testbench;
    import nnl2_pkg::*;

    localparam int unsigned LONG_HOLD  = 3000;
    localparam int unsigned SETTLE     = 10;
    localparam int unsigned DRAIN_WAIT = 300;
    localparam logic [PADDR_W-1:0] REF_ROWS_ADDR = {REG_REF_ROWS, 2'b00};
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 3'h4;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  dist_sq;
    } match_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      cmd = CMD_LOAD;
    logic [IN_ROW_W-1:0]       row = '0;
    logic [IN_DIM_W-1:0]       dim = '0;
    logic [IN_VAL_W-1:0]       value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]         best_dist_sq;

    logic [IN_VAL_W-1:0] ref_components [MAX_ROWS * DIM];
    logic [IN_VAL_W-1:0] query_components [DIM];
    int unsigned         search_rows = 0;
    match_t              pending_matches [$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;

    nearest_neighbor_l2_search_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .row          (row),
        .dim          (dim),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .best_index   (best_index),
        .best_dist_sq (best_dist_sq)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (holds_started != hold_requests)
        begin
            holds_started <= holds_started + 1;
            hold_left     <= LONG_HOLD;
            out_ready     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_matches.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result index %h dist %h", $time,
                         best_index, best_dist_sq);
            end
            else
            begin
                want = pending_matches.pop_front();
                if (best_index !== want.index)
                begin
                    mismatches++;
                    $display("%0t: best_index expected %h actual %h", $time,
                             want.index, best_index);
                end
                if (best_dist_sq !== want.dist_sq)
                begin
                    mismatches++;
                    $display("%0t: best_dist_sq expected %h actual %h", $time,
                             want.dist_sq, best_dist_sq);
                end
            end
        end
    end

    function automatic match_t nearest_row();
        match_t            m;
        longint unsigned   acc;
        longint unsigned   diff;
        int unsigned       a;
        int unsigned       b;
        int unsigned       n;
        m.index   = INDEX_NONE;
        m.dist_sq = '0;
        n = (search_rows > MAX_ROWS) ? MAX_ROWS : search_rows;
        for (int r = 0; r < n; r++)
        begin
            acc = 0;
            for (int d = 0; d < DIM; d++)
            begin
                a    = ref_components[r * DIM + d];
                b    = query_components[d];
                diff = (a > b) ? a - b : b - a;
                acc += diff * diff;
            end
            if (r == 0 || acc < m.dist_sq)
            begin
                m.index   = INDEX_W'(r);
                m.dist_sq = DIST_W'(acc);
            end
        end
        return m;
    endfunction

    task automatic send_item(input logic c, input logic [IN_ROW_W-1:0] r,
                             input logic [IN_DIM_W-1:0] d, input logic [IN_VAL_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        row      <= r;
        dim      <= d;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        if (c == CMD_LOAD)
        begin
            ref_components[int'(r) * DIM + int'(d)] = v;
        end
        else
        begin
            query_components[d] = v;
            if (d == DIM_LAST)
                pending_matches.insert(pending_matches.size(), nearest_row());
        end
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_ref_rows_readback();
        logic [DATA_W-1:0] rd;
        apb_access(1'b0, REF_ROWS_ADDR, '0, rd);
        if (rd !== DATA_W'(search_rows))
        begin
            mismatches++;
            $display("%0t: ref_rows readback expected %h actual %h", $time,
                     DATA_W'(search_rows), rd);
        end
    endtask

    task automatic set_ref_rows(input int unsigned n);
        logic [DATA_W-1:0] rd;
        wait_drained();
        apb_access(1'b1, REF_ROWS_ADDR, DATA_W'(n), rd);
        search_rows = n;
        check_ref_rows_readback();
    endtask

    task automatic run_random_traffic(input int unsigned items);
        logic                c;
        logic [IN_ROW_W-1:0] r;
        logic [IN_DIM_W-1:0] d;
        logic [IN_VAL_W-1:0] v;
        int unsigned         pick;
        repeat (items)
        begin
            pick = $urandom_range(7);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : IN_VAL_W'($urandom);
            r = IN_ROW_W'($urandom);
            if ($urandom_range(99) < 45)
            begin
                c = CMD_LOAD;
                if ($urandom_range(3) != 0)
                    r = IN_ROW_W'($urandom_range(1));
                d = IN_DIM_W'($urandom);
            end
            else
            begin
                c = CMD_QUERY;
                d = ($urandom_range(3) == 0) ? DIM_LAST : IN_DIM_W'($urandom_range(DIM - 2));
            end
            send_item(c, r, d, v);
        end
        end_burst();
    endtask

    task automatic test_no_rows();
        logic [DATA_W-1:0] rd;
        set_ref_rows(0);
        apb_access(1'b1, UNMAPPED_ADDR, DATA_W'(5), rd);
        check_ref_rows_readback();
        for (int d = 0; d < DIM; d++)
            send_item(CMD_QUERY, IN_ROW_W'($urandom), IN_DIM_W'(d), '1);
        end_burst();
    endtask

    task automatic test_reference_fill();
        for (int r = 0; r < 2; r++)
            for (int d = 0; d < DIM; d++)
                send_item(CMD_LOAD, IN_ROW_W'(r), IN_DIM_W'(d), '0);
        end_burst();
    endtask

    task automatic test_extremes();
        set_ref_rows(1);
        send_item(CMD_QUERY, '1, DIM_LAST, '1);
        end_burst();
        set_ref_rows(2);
        send_item(CMD_QUERY, '0, DIM_LAST, '1);
        send_item(CMD_LOAD, 10'd1, 7'd0, '1);
        send_item(CMD_QUERY, '0, DIM_LAST, '1);
        send_item(CMD_LOAD, 10'd0, 7'd0, '1);
        send_item(CMD_LOAD, 10'd0, 7'd1, 16'd1);
        send_item(CMD_QUERY, '0, DIM_LAST, '1);
        send_item(CMD_QUERY, 10'h155, 7'd0, 16'h8000);
        send_item(CMD_QUERY, 10'h2AA, 7'd63, 16'h7FFF);
        send_item(CMD_QUERY, '1, DIM_LAST, 16'h0001);
        send_item(CMD_LOAD, 10'h3FF, 7'h7F, 16'hAAAA);
        send_item(CMD_LOAD, 10'h200, 7'h40, 16'h5555);
        send_item(CMD_QUERY, 10'h0AA, DIM_LAST, '0);
        end_burst();
    endtask

    task automatic test_full_row_count();
        set_ref_rows(MAX_ROWS);
        send_item(CMD_LOAD, 10'h3FF, 7'h00, 16'h1234);
        send_item(CMD_LOAD, 10'h1FF, 7'h3F, 16'hFFFF);
        send_item(CMD_QUERY, 10'h3FF, 7'h7E, 16'hC3A5);
        send_item(CMD_LOAD, 10'h100, 7'h7F, 16'h0000);
        end_burst();
        set_ref_rows(2);
    endtask

    task automatic test_random_traffic();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_traffic(37);
        src_idle_pct = 64;
        set_ref_rows(1);
        run_random_traffic(37);
        src_idle_pct   = 0;
        sink_stall_pct = 64;
        set_ref_rows(2);
        run_random_traffic(37);
        src_idle_pct   = 9;
        sink_stall_pct = 9;
        run_random_traffic(37);
    endtask

    task automatic test_output_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_ref_rows(2);
        hold_requests <= hold_requests + 1;
        repeat (6)
        begin
            send_item(CMD_LOAD, IN_ROW_W'($urandom_range(1)), IN_DIM_W'($urandom),
                      IN_VAL_W'($urandom));
            send_item(CMD_QUERY, IN_ROW_W'($urandom), DIM_LAST, IN_VAL_W'($urandom));
        end
        end_burst();
        wait_drained();
        run_random_traffic(20);
    endtask

    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_rows();
        test_reference_fill();
        test_extremes();
        test_full_row_count();
        test_random_traffic();
        test_output_backpressure();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
